FILE: rtl/irc_pkg.sv
// Package for the IPv4 receive check: shared constants, verdict codes and the
// record passed from the header parser to the verdict stage.
// No dependencies.
package irc_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  PROTO_UDP        = 8'd17;
  localparam logic [7:0]  PROTO_ICMP       = 8'd1;
  localparam logic [3:0]  MIN_HEADER_WORDS = 4'd5;
  localparam logic [16:0] MIN_FRAME_BYTES  = 17'd20;
  localparam logic [3:0]  IP_VERSION       = 4'd4;
  localparam logic [15:0] SUM_ALL_ONES     = 16'hFFFF;
  localparam logic [15:0] INDEX_MAX        = 16'hFFFF;

  localparam logic [15:0] IDX_VER_IHL  = 16'd0;
  localparam logic [15:0] IDX_LEN_HI   = 16'd2;
  localparam logic [15:0] IDX_LEN_LO   = 16'd3;
  localparam logic [15:0] IDX_PROTO    = 16'd9;
  localparam logic [15:0] IDX_SRC_LO   = 16'd12;
  localparam logic [15:0] IDX_SRC_HI   = 16'd15;
  localparam logic [15:0] IDX_DST_LO   = 16'd16;
  localparam logic [15:0] IDX_DST_HI   = 16'd19;

  typedef enum logic [2:0] {
    VERDICT_UDP         = 3'd0,
    VERDICT_ICMP        = 3'd1,
    VERDICT_PROTO_UNRCH = 3'd2,
    VERDICT_TOO_SHORT   = 3'd3,
    VERDICT_BAD_VERSION = 3'd4,
    VERDICT_TRUNCATED   = 3'd5,
    VERDICT_BAD_CSUM    = 3'd6,
    VERDICT_NOT_FOR_US  = 3'd7
  } verdict_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic        too_short;
    logic        version_good;
    logic        truncated;
    logic        sum_ok;
    logic [31:0] dest;
    logic [31:0] source;
    logic [7:0]  proto;
  } rec_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

FILE: rtl/irc_front.sv
// Front stage: accepts frame bytes, captures header fields, accumulates the
// header checksum and classifies each byte. Pushes records into the queue.
// Depends on irc_pkg.
module irc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_frame_byte,
  input  logic              in_frame_last,
  input  irc_pkg::q_stat_t  q_stat,
  output logic              push,
  output irc_pkg::rec_t     push_rec
);

  logic [15:0] idx_r,   idx_nxt;
  logic [3:0]  hw_r,    hw_nxt;
  logic [15:0] plen_r,  plen_nxt;
  logic [15:0] sum_r,   sum_nxt;
  logic [7:0]  hi_r,    hi_nxt;
  logic        vg_r,    vg_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r,   src_nxt;
  logic [31:0] dst_r,   dst_nxt;

  logic [3:0]  hw_c;
  logic [15:0] plen_c;
  logic [15:0] sum_c;
  logic [7:0]  hi_c;
  logic        vg_c;
  logic [7:0]  proto_c;
  logic [31:0] src_c;
  logic [31:0] dst_c;
  logic [15:0] hdr_bytes;
  logic        ok_len;
  logic        payload;
  logic [16:0] flen;
  logic [16:0] s17;
  logic        accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hw_c    = hw_r;
    plen_c  = plen_r;
    vg_c    = vg_r;
    proto_c = proto_r;
    src_c   = src_r;
    dst_c   = dst_r;
    if (idx_r == irc_pkg::IDX_VER_IHL) begin
      hw_c = in_frame_byte[3:0];
      vg_c = (in_frame_byte[7:4] == irc_pkg::IP_VERSION);
    end else if (idx_r == irc_pkg::IDX_LEN_HI) begin
      plen_c = {in_frame_byte, plen_r[7:0]};
    end else if (idx_r == irc_pkg::IDX_LEN_LO) begin
      plen_c = {plen_r[15:8], in_frame_byte};
    end else if (idx_r == irc_pkg::IDX_PROTO) begin
      proto_c = in_frame_byte;
    end else if (idx_r >= irc_pkg::IDX_SRC_LO && idx_r <= irc_pkg::IDX_SRC_HI) begin
      src_c = {src_r[23:0], in_frame_byte};
    end else if (idx_r >= irc_pkg::IDX_DST_LO && idx_r <= irc_pkg::IDX_DST_HI) begin
      dst_c = {dst_r[23:0], in_frame_byte};
    end

    hdr_bytes = {10'd0, hw_c, 2'b00};
    ok_len    = (hw_c >= irc_pkg::MIN_HEADER_WORDS);

    hi_c  = hi_r;
    sum_c = sum_r;
    s17   = {1'b0, sum_r} + {1'b0, hi_r, in_frame_byte};
    if (idx_r < hdr_bytes) begin
      if (!idx_r[0]) begin
        hi_c = in_frame_byte;
      end else begin
        sum_c = s17[15:0] + {15'd0, s17[16]};
      end
    end

    payload = ok_len && (idx_r >= hdr_bytes) && (idx_r < plen_c);
    flen    = {1'b0, idx_r} + 17'd1;

    push_rec.payload_valid = payload;
    push_rec.payload_byte  = payload ? in_frame_byte : 8'd0;
    push_rec.frame_end     = in_frame_last;
    push_rec.too_short     = (flen < irc_pkg::MIN_FRAME_BYTES) || !ok_len;
    push_rec.version_good  = vg_c;
    push_rec.truncated     = ({1'b0, plen_c} > flen) || ({1'b0, hdr_bytes} > flen);
    push_rec.sum_ok        = (sum_c == irc_pkg::SUM_ALL_ONES);
    push_rec.dest          = dst_c;
    push_rec.source        = src_c;
    push_rec.proto         = proto_c;

    push = accept && (payload || in_frame_last);

    idx_nxt   = idx_r;
    hw_nxt    = hw_r;
    plen_nxt  = plen_r;
    sum_nxt   = sum_r;
    hi_nxt    = hi_r;
    vg_nxt    = vg_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    if (accept) begin
      if (in_frame_last) begin
        idx_nxt   = 16'd0;
        hw_nxt    = 4'd0;
        plen_nxt  = 16'd0;
        sum_nxt   = 16'd0;
        hi_nxt    = 8'd0;
        vg_nxt    = 1'b0;
        proto_nxt = 8'd0;
        src_nxt   = 32'd0;
        dst_nxt   = 32'd0;
      end else begin
        idx_nxt   = (idx_r == irc_pkg::INDEX_MAX) ? idx_r : idx_r + 16'd1;
        hw_nxt    = hw_c;
        plen_nxt  = plen_c;
        sum_nxt   = sum_c;
        hi_nxt    = hi_c;
        vg_nxt    = vg_c;
        proto_nxt = proto_c;
        src_nxt   = src_c;
        dst_nxt   = dst_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 16'd0;
      hw_r    <= 4'd0;
      plen_r  <= 16'd0;
      sum_r   <= 16'd0;
      hi_r    <= 8'd0;
      vg_r    <= 1'b0;
      proto_r <= 8'd0;
      src_r   <= 32'd0;
      dst_r   <= 32'd0;
    end else begin
      idx_r   <= idx_nxt;
      hw_r    <= hw_nxt;
      plen_r  <= plen_nxt;
      sum_r   <= sum_nxt;
      hi_r    <= hi_nxt;
      vg_r    <= vg_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
    end
  end

endmodule

FILE: rtl/irc_queue.sv
// Short register queue of classified byte records between front and back.
// Depends on irc_pkg.
module irc_queue #(
  parameter int DEPTH = irc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  irc_pkg::rec_t     push_rec,
  input  logic              pop,
  output irc_pkg::rec_t     head_rec,
  output irc_pkg::q_stat_t  q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  irc_pkg::rec_t   entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r,    cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign q_stat.valid = (cnt_r != '0);
  assign q_stat.full  = (cnt_r == FULL_CNT);
  assign head_rec     = entry_r[rd_ptr_r];
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && q_stat.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

FILE: rtl/irc_back.sv
// Back stage: holds the local address register, forms the frame verdict from
// the queue head and drives the registered result channel.
// Depends on irc_pkg.
module irc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_local_address,
  input  irc_pkg::rec_t     head_rec,
  input  irc_pkg::q_stat_t  q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_payload_byte,
  output logic              out_payload_valid,
  output logic              out_frame_end,
  output logic [2:0]        out_verdict,
  output logic [31:0]       out_source_address,
  output logic [7:0]        out_protocol_number
);

  logic [31:0]       local_addr_r;
  logic              valid_r;
  logic [7:0]        byte_r;
  logic              pvalid_r;
  logic              fend_r;
  irc_pkg::verdict_t verdict_r, verdict_nxt;
  logic [31:0]       src_r;
  logic [7:0]        proto_r;

  assign cfg_ready = 1'b1;
  assign pop       = q_stat.valid && (!valid_r || out_ready);

  always_comb begin
    if (!head_rec.frame_end) begin
      verdict_nxt = irc_pkg::VERDICT_UDP;
    end else if (head_rec.too_short) begin
      verdict_nxt = irc_pkg::VERDICT_TOO_SHORT;
    end else if (!head_rec.version_good) begin
      verdict_nxt = irc_pkg::VERDICT_BAD_VERSION;
    end else if (head_rec.truncated) begin
      verdict_nxt = irc_pkg::VERDICT_TRUNCATED;
    end else if (!head_rec.sum_ok) begin
      verdict_nxt = irc_pkg::VERDICT_BAD_CSUM;
    end else if (head_rec.dest != local_addr_r) begin
      verdict_nxt = irc_pkg::VERDICT_NOT_FOR_US;
    end else if (head_rec.proto == irc_pkg::PROTO_UDP) begin
      verdict_nxt = irc_pkg::VERDICT_UDP;
    end else if (head_rec.proto == irc_pkg::PROTO_ICMP) begin
      verdict_nxt = irc_pkg::VERDICT_ICMP;
    end else begin
      verdict_nxt = irc_pkg::VERDICT_PROTO_UNRCH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= 32'd0;
      valid_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        local_addr_r <= cfg_local_address;
      end
      if (pop) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_r    <= head_rec.payload_byte;
      pvalid_r  <= head_rec.payload_valid;
      fend_r    <= head_rec.frame_end;
      verdict_r <= verdict_nxt;
      src_r     <= head_rec.frame_end ? head_rec.source : 32'd0;
      proto_r   <= head_rec.frame_end ? head_rec.proto : 8'd0;
    end
  end

  assign out_valid           = valid_r;
  assign out_payload_byte    = byte_r;
  assign out_payload_valid   = pvalid_r;
  assign out_frame_end       = fend_r;
  assign out_verdict         = verdict_r;
  assign out_source_address  = src_r;
  assign out_protocol_number = proto_r;

endmodule

FILE: rtl/ipv4_receive_check.sv
// IPv4 receive check, top level. Takes one frame byte per cycle, header first,
// and sustains one byte per cycle while in_ready is high. The front stage does
// field capture and one 16-bit end-around-carry add per header byte pair; a
// result (payload byte and/or frame verdict) is queued, then registered at the
// output before it can be taken. A queue of QUEUE_DEPTH records sits between
// front and back, so in_ready drops only when the result side has stalled long
// enough to fill it. Bytes that are neither payload nor last produce no result.
// Depends on irc_pkg, irc_front, irc_queue, irc_back.
module ipv4_receive_check #(
  parameter int QUEUE_DEPTH = irc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_local_address,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_valid,
  output logic        out_frame_end,
  output logic [2:0]  out_verdict,
  output logic [31:0] out_source_address,
  output logic [7:0]  out_protocol_number
);

  irc_pkg::rec_t    push_rec;
  irc_pkg::rec_t    head_rec;
  irc_pkg::q_stat_t q_stat;
  logic             push;
  logic             pop;

  irc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_frame_byte (in_frame_byte),
    .in_frame_last (in_frame_last),
    .q_stat        (q_stat),
    .push          (push),
    .push_rec      (push_rec)
  );

  irc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .q_stat   (q_stat)
  );

  irc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_local_address   (cfg_local_address),
    .head_rec            (head_rec),
    .q_stat              (q_stat),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_payload_byte    (out_payload_byte),
    .out_payload_valid   (out_payload_valid),
    .out_frame_end       (out_frame_end),
    .out_verdict         (out_verdict),
    .out_source_address  (out_source_address),
    .out_protocol_number (out_protocol_number)
  );

`ifndef ASSERT_OFF
  a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_payload_valid || out_frame_end))
    else $error("result carries neither payload nor frame end");

  a_verdict_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_frame_end) |->
      (out_verdict == irc_pkg::VERDICT_UDP && out_source_address == 32'd0 &&
       out_protocol_number == 8'd0))
    else $error("frame fields set on a non-final result");

  a_last_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_frame_last && !q_stat.valid && !out_valid)
      |=> ##1 (out_valid && out_frame_end))
    else $error("frame end did not reach the output");
`endif

endmodule

FILE: tb/testbench.sv
// Testbench for ipv4_receive_check: drives IPv4 frames one byte per transaction,
// predicts payload and verdict transactions in a scoreboard class and checks them.
// Depends on irc_pkg and the ipv4_receive_check RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int RANDOM_BYTES   = 750;
  localparam int PHASE_BYTES    = 250;

  localparam logic [3:0] V4     = irc_pkg::IP_VERSION;
  localparam logic [7:0] P_UDP  = irc_pkg::PROTO_UDP;
  localparam logic [7:0] P_ICMP = irc_pkg::PROTO_ICMP;

  typedef struct {
    logic [7:0]        payload_byte;
    logic              payload_valid;
    logic              frame_end;
    irc_pkg::verdict_t verdict;
    logic [31:0]       source_address;
    logic [7:0]        protocol_number;
  } rx_result_t;

  class rx_scoreboard;
    logic [31:0] local_addr = '0;
    logic [15:0] byte_index = '0;
    logic [3:0]  header_words = '0;
    logic [15:0] packet_length = '0;
    logic [15:0] sum_acc = '0;
    logic [7:0]  high_hold = '0;
    logic        version_good = 1'b0;
    logic [7:0]  proto_hold = '0;
    logic [31:0] source_hold = '0;
    logic [31:0] dest_hold = '0;
    rx_result_t  expected_q[$];
    int          errors = 0;

    function void clear_frame();
      byte_index    = '0;
      header_words  = '0;
      packet_length = '0;
      sum_acc       = '0;
      high_hold     = '0;
      version_good  = 1'b0;
      proto_hold    = '0;
      source_hold   = '0;
      dest_hold     = '0;
    endfunction

    // one accepted input transaction
    function void note_byte(logic [7:0] b, logic last);
      int unsigned idx;
      int unsigned hdr_bytes;
      int unsigned flen;
      logic [16:0] s;
      logic        payload;
      logic        ok_len;
      rx_result_t  r;
      idx = byte_index;
      if (idx == 0) begin
        header_words = b[3:0];
        version_good = (b[7:4] == irc_pkg::IP_VERSION);
      end else if (idx == 2) begin
        packet_length[15:8] = b;
      end else if (idx == 3) begin
        packet_length[7:0] = b;
      end else if (idx == 9) begin
        proto_hold = b;
      end else if (idx >= 12 && idx <= 15) begin
        source_hold = {source_hold[23:0], b};
      end else if (idx >= 16 && idx <= 19) begin
        dest_hold = {dest_hold[23:0], b};
      end
      hdr_bytes = header_words * 4;
      ok_len = (header_words >= irc_pkg::MIN_HEADER_WORDS);
      if (idx < hdr_bytes) begin
        if (idx % 2 == 0) begin
          high_hold = b;
        end else begin
          s = sum_acc + {high_hold, b};
          s = s[15:0] + s[16];
          sum_acc = s[15:0];
        end
      end
      payload = ok_len && idx >= hdr_bytes && idx < packet_length;
      r.payload_byte    = payload ? b : 8'd0;
      r.payload_valid   = payload;
      r.frame_end       = last;
      r.verdict         = irc_pkg::VERDICT_UDP;
      r.source_address  = '0;
      r.protocol_number = '0;
      if (last) begin
        flen = idx + 1;
        if (flen < irc_pkg::MIN_FRAME_BYTES || !ok_len) begin
          r.verdict = irc_pkg::VERDICT_TOO_SHORT;
        end else if (!version_good) begin
          r.verdict = irc_pkg::VERDICT_BAD_VERSION;
        end else if (packet_length > flen || hdr_bytes > flen) begin
          r.verdict = irc_pkg::VERDICT_TRUNCATED;
        end else if (sum_acc != irc_pkg::SUM_ALL_ONES) begin
          r.verdict = irc_pkg::VERDICT_BAD_CSUM;
        end else if (dest_hold != local_addr) begin
          r.verdict = irc_pkg::VERDICT_NOT_FOR_US;
        end else if (proto_hold == irc_pkg::PROTO_UDP) begin
          r.verdict = irc_pkg::VERDICT_UDP;
        end else if (proto_hold == irc_pkg::PROTO_ICMP) begin
          r.verdict = irc_pkg::VERDICT_ICMP;
        end else begin
          r.verdict = irc_pkg::VERDICT_PROTO_UNRCH;
        end
        r.source_address  = source_hold;
        r.protocol_number = proto_hold;
        clear_frame();
      end else if (byte_index != irc_pkg::INDEX_MAX) begin
        byte_index = byte_index + 16'd1;
      end
      if (payload || last) expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(rx_result_t got);
      rx_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("output transaction with nothing expected");
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("payload_byte", exp_r.payload_byte, got.payload_byte);
      compare_field("payload_valid", exp_r.payload_valid, got.payload_valid);
      compare_field("frame_end", exp_r.frame_end, got.frame_end);
      compare_field("verdict", exp_r.verdict, got.verdict);
      compare_field("source_address", exp_r.source_address, got.source_address);
      compare_field("protocol_number", exp_r.protocol_number, got.protocol_number);
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_local_address = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_frame_byte = '0;
  logic        in_frame_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_payload_byte;
  logic        out_payload_valid;
  logic        out_frame_end;
  logic [2:0]  out_verdict;
  logic [31:0] out_source_address;
  logic [7:0]  out_protocol_number;

  rx_scoreboard sb = new();
  logic [7:0]   fbuf[$];
  logic [31:0]  cur_local = '0;
  int           bytes_sent = 0;
  int           idle_cycles = 0;
  bit           tx_idle_en = 1'b1;
  bit           rx_idle_en = 1'b1;
  bit           rx_hold_req = 1'b0;
  int           rx_hold_len = 0;

  ipv4_receive_check u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_local_address   (cfg_local_address),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_frame_byte       (in_frame_byte),
    .in_frame_last       (in_frame_last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_payload_byte    (out_payload_byte),
    .out_payload_valid   (out_payload_valid),
    .out_frame_end       (out_frame_end),
    .out_verdict         (out_verdict),
    .out_source_address  (out_source_address),
    .out_protocol_number (out_protocol_number)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // monitor and watchdog
  always @(posedge clk) begin
    rx_result_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.payload_byte    = out_payload_byte;
        got.payload_valid   = out_payload_valid;
        got.frame_end       = out_frame_end;
        got.verdict         = irc_pkg::verdict_t'(out_verdict);
        got.source_address  = out_source_address;
        got.protocol_number = out_protocol_number;
        sb.check_result(got);
      end
      if (in_valid && in_ready) sb.note_byte(in_frame_byte, in_frame_last);
      if (cfg_valid && cfg_ready) sb.local_addr = cfg_local_address;
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[ipv4_receive_check] ERROR");
        $finish;
      end
    end
  end

  // result side: random stalls plus an occasional long hold-off
  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic void make_frame(logic [3:0] ver, logic [3:0] ihl, logic [15:0] tot_len,
                                     logic [7:0] proto, logic [31:0] src, logic [31:0] dst,
                                     bit csum_ok, int flen);
    int          hdr_n;
    logic [16:0] s;
    logic [15:0] csum;
    fbuf.delete();
    hdr_n = (ihl < irc_pkg::MIN_HEADER_WORDS) ? 20 : ihl * 4;
    fbuf.push_back({ver, ihl});
    fbuf.push_back(8'($urandom));
    fbuf.push_back(tot_len[15:8]);
    fbuf.push_back(tot_len[7:0]);
    repeat (5) fbuf.push_back(8'($urandom));
    fbuf.push_back(proto);
    fbuf.push_back(8'd0);
    fbuf.push_back(8'd0);
    for (int i = 3; i >= 0; i--) fbuf.push_back(src[8*i +: 8]);
    for (int i = 3; i >= 0; i--) fbuf.push_back(dst[8*i +: 8]);
    while (fbuf.size() < hdr_n) fbuf.push_back(8'($urandom));
    s = '0;
    for (int i = 0; i + 1 < ihl * 4; i += 2) begin
      s = s[15:0] + {fbuf[i], fbuf[i+1]};
      s = s[15:0] + s[16];
    end
    csum = ~s[15:0];
    if (!csum_ok) csum = csum ^ (16'd1 << $urandom_range(0, 15));
    fbuf[10] = csum[15:8];
    fbuf[11] = csum[7:0];
    while (fbuf.size() < flen) fbuf.push_back(8'($urandom));
    while (fbuf.size() > flen) void'(fbuf.pop_back());
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    in_valid      <= 1'b1;
    in_frame_byte <= b;
    in_frame_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic send_frame();
    foreach (fbuf[i]) send_byte(fbuf[i], i == fbuf.size() - 1);
  endtask

  task automatic frame_out(logic [3:0] ver, logic [3:0] ihl, logic [15:0] tot_len,
                           logic [7:0] proto, logic [31:0] src, logic [31:0] dst,
                           bit csum_ok, int flen);
    make_frame(ver, ihl, tot_len, proto, src, dst, csum_ok, flen);
    send_frame();
  endtask

  // wait until every expected transaction is out and the pipeline is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_local(logic [31:0] addr);
    cfg_valid         <= 1'b1;
    cfg_local_address <= addr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_local = addr;
  endtask

  task automatic random_frame();
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [15:0] tot;
    logic [7:0]  proto;
    logic [31:0] dst;
    bit          ok;
    int          flen;
    int          pay;
    int          kind;
    kind = $urandom_range(0, 99);
    ver  = V4;
    ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : irc_pkg::MIN_HEADER_WORDS;
    pay  = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
    tot  = 16'(ihl * 4 + pay);
    flen = tot + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0);
    case ($urandom_range(0, 3))
      0, 1: proto = P_UDP;
      2: proto = P_ICMP;
      default: proto = 8'($urandom);
    endcase
    dst = cur_local;
    ok  = 1'b1;
    if (kind < 55) begin
    end else if (kind < 62) begin
      dst = $urandom;
    end else if (kind < 68) begin
      ok = 1'b0;
    end else if (kind < 74) begin
      ver = 4'($urandom);
    end else if (kind < 79) begin
      ihl = 4'($urandom_range(0, 4));
    end else if (kind < 85) begin
      flen = $urandom_range(1, flen - 1);
    end else if (kind < 89) begin
      tot  = 16'($urandom_range(0, ihl * 4 - 1));
      flen = ihl * 4 + $urandom_range(0, 8);
    end else if (kind < 92) begin
      flen = $urandom_range(1, 19);
    end else if (kind < 95) begin
      tot = 16'($urandom);
    end
    make_frame(ver, ihl, tot, proto, $urandom, dst, ok, flen);
    if (kind >= 95) begin
      foreach (fbuf[i]) fbuf[i] = 8'($urandom);
    end
    send_frame();
  endtask

  initial begin
    int start;
    int rand_sent;
    int phase;
    logic [31:0] addr;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames, local address at its reset value
    frame_out(V4, 4'd5, 16'd20, P_UDP, '0, cur_local, 1, 20);
    frame_out(V4, 4'd5, 16'd28, P_ICMP, '1, cur_local, 1, 31);
    frame_out(V4, 4'd5, 16'd24, 8'd6, $urandom, cur_local, 1, 24);
    frame_out(V4, 4'd5, 16'd21, 8'd0, $urandom, cur_local, 1, 21);
    frame_out(V4, 4'd5, 16'd21, 8'hFF, $urandom, cur_local, 1, 22);
    frame_out(V4, 4'd15, 16'd70, P_UDP, $urandom, cur_local, 1, 70);
    frame_out(V4, 4'd0, 16'd30, P_UDP, $urandom, cur_local, 1, 30);
    frame_out(V4, 4'd4, 16'd30, P_UDP, $urandom, cur_local, 1, 30);
    frame_out(4'd0, 4'd5, 16'd30, P_UDP, $urandom, cur_local, 1, 30);
    frame_out(4'd15, 4'd5, 16'd30, P_UDP, $urandom, cur_local, 1, 30);
    frame_out(V4, 4'd15, 16'd60, P_UDP, $urandom, cur_local, 1, 30);
    frame_out(V4, 4'd5, 16'd100, P_UDP, $urandom, cur_local, 1, 40);
    frame_out(V4, 4'd5, 16'hFFFF, P_UDP, $urandom, cur_local, 1, 40);
    frame_out(V4, 4'd5, 16'd30, P_UDP, $urandom, cur_local, 0, 30);
    frame_out(V4, 4'd5, 16'd30, P_UDP, $urandom, 32'h0A000001, 1, 30);
    frame_out(V4, 4'd6, 16'd0, P_UDP, $urandom, cur_local, 1, 30);
    frame_out(V4, 4'd5, 16'd20, P_UDP, $urandom, cur_local, 1, 1);
    frame_out(V4, 4'd5, 16'd20, P_UDP, $urandom, cur_local, 1, 19);
    drain();

    write_local('1);
    frame_out(V4, 4'd5, 16'd24, P_UDP, $urandom, '1, 1, 24);
    frame_out(V4, 4'd5, 16'd24, P_ICMP, $urandom, '0, 1, 24);
    drain();

    // long result-side hold-off while the input keeps streaming
    rx_hold_len = 80;
    rx_hold_req = 1'b1;
    frame_out(V4, 4'd5, 16'd120, P_UDP, $urandom, '1, 1, 120);
    drain();

    rand_sent = 0;
    phase = 0;
    while (rand_sent < RANDOM_BYTES) begin
      if (phase == 0) addr = '0;
      else if (phase == 1) addr = '1;
      else addr = $urandom;
      if (rand_sent >= RANDOM_BYTES - PHASE_BYTES) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      drain();
      write_local(addr);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) random_frame();
      rand_sent += bytes_sent - start;
      phase++;
    end
    drain();

    if (sb.expected_q.size() != 0) begin
      $error("%0d expected transactions never arrived", sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[ipv4_receive_check] OK");
    end else begin
      $display("[ipv4_receive_check] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/irc_pkg.sv
rtl/irc_front.sv
rtl/irc_queue.sv
rtl/irc_back.sv
rtl/ipv4_receive_check.sv
tb/testbench.sv
